>>> rtl/core/cstm_pkg.sv
// ----------------------------------------------------------------------------
// cstm_pkg
// Shared types and constants of the cam-synced two-motor drive unit.
// ----------------------------------------------------------------------------
package cstm_pkg;

  // Parameter defaults
  localparam int HISTORY_BITS_DEF   = 16;
  localparam int SETTLE_SAMPLES_DEF = 15;

  // Field widths
  localparam int MASK_W  = 16;
  localparam int LEVEL_W = 10;
  localparam int DRIVE_W = 11;
  localparam int MODE_W  = 3;
  localparam int PHASE_W = 3;
  localparam int CNT_W   = 4;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_SEL_MASK  = 1'b0;   // paddr[2] == 0: debounce_mask
  localparam logic REG_SEL_LEVEL = 1'b1;   // paddr[2] == 1: drive_level
  localparam logic [MASK_W-1:0]  MASK_RST  = 16'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_RST = 10'd512;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FWD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LEFT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd4;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_L_HIGH  = 3'd1;
  localparam logic [PHASE_W-1:0] PH_L_LOW   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_R_HIGH  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_R_LOW   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_RUN     = 3'd5;
  localparam logic [PHASE_W-1:0] PH_L_HELD  = 3'd6;
  localparam logic [PHASE_W-1:0] PH_R_HELD  = 3'd7;

  // Control from the sequencer to the debouncers
  typedef struct packed {
    logic commit;   // a word is processed this cycle
    logic sample;   // shift the switch samples into the histories
  } smp_ctl_t;

endpackage

>>> rtl/core/cstm_cfg.sv
// ----------------------------------------------------------------------------
// cstm_cfg
// APB-style configuration registers: debounce mask and drive level.
// ----------------------------------------------------------------------------
module cstm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cstm_pkg::PADDR_W-1:0]       paddr,
  input  logic [cstm_pkg::PDATA_W-1:0]       pwdata,
  output logic [cstm_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  output logic [cstm_pkg::MASK_W-1:0]        debounce_mask,
  output logic [cstm_pkg::LEVEL_W-1:0]       drive_level
);

  logic [cstm_pkg::MASK_W-1:0]  mask_r;
  logic [cstm_pkg::LEVEL_W-1:0] level_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write registers, decoded on the word address bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= cstm_pkg::MASK_RST;
      level_r <= cstm_pkg::LEVEL_RST;
    end else if (wr_en) begin
      if (paddr[2] == cstm_pkg::REG_SEL_MASK) begin
        mask_r <= pwdata[cstm_pkg::MASK_W-1:0];
      end else begin
        level_r <= pwdata[cstm_pkg::LEVEL_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (paddr[2] == cstm_pkg::REG_SEL_MASK) begin
      prdata = {{(cstm_pkg::PDATA_W-cstm_pkg::MASK_W){1'b0}}, mask_r};
    end else begin
      prdata = {{(cstm_pkg::PDATA_W-cstm_pkg::LEVEL_W){1'b0}}, level_r};
    end
  end

  assign debounce_mask = mask_r;
  assign drive_level   = level_r;

endmodule

>>> rtl/core/cstm_debounce.sv
// ----------------------------------------------------------------------------
// cstm_debounce
// Shift-register debounce of one cam switch with a settled level.
// ----------------------------------------------------------------------------
module cstm_debounce #(
  parameter int HISTORY_BITS = cstm_pkg::HISTORY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cstm_pkg::smp_ctl_t           ctl,
  input  logic                         raw,
  input  logic [cstm_pkg::MASK_W-1:0]  debounce_mask,
  output logic                         level_post
);

  logic [HISTORY_BITS-1:0] hist_r;
  logic [HISTORY_BITS-1:0] hist_nxt;
  logic                    level_r;
  logic [HISTORY_BITS-1:0] mask_w;
  logic [HISTORY_BITS-1:0] masked;
  logic [31:0]             mask_ext;

  // Fit the register mask to the history length
  assign mask_ext = {{(32-cstm_pkg::MASK_W){1'b0}}, debounce_mask};
  assign mask_w   = mask_ext[HISTORY_BITS-1:0];

  // Shift in the new sample and settle when all masked bits agree
  assign hist_nxt = {hist_r[HISTORY_BITS-2:0], raw};
  assign masked   = hist_nxt & mask_w;

  always_comb begin
    priority if (masked == mask_w) begin
      level_post = 1'b1;
    end else if (masked == '0) begin
      level_post = 1'b0;
    end else begin
      level_post = level_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      level_r <= 1'b0;
    end else if (ctl.commit && ctl.sample) begin
      hist_r  <= hist_nxt;
      level_r <= level_post;
    end
  end

endmodule

>>> rtl/core/cstm_ctrl.sv
// ----------------------------------------------------------------------------
// cstm_ctrl
// Homing and run sequencer: phase, modes, remembered cam levels and drives.
// ----------------------------------------------------------------------------
module cstm_ctrl #(
  parameter int SETTLE_SAMPLES = cstm_pkg::SETTLE_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                commit,
  input  logic                                click_up,
  input  logic                                click_down,
  input  logic                                click_left,
  input  logic                                click_right,
  input  logic                                click_stop,
  input  logic                                left_level,
  input  logic                                right_level,
  input  logic [cstm_pkg::LEVEL_W-1:0]        drive_level,
  output cstm_pkg::smp_ctl_t                  smp_ctl,
  output logic signed [cstm_pkg::DRIVE_W-1:0] left_drive,
  output logic signed [cstm_pkg::DRIVE_W-1:0] right_drive,
  output logic [cstm_pkg::MODE_W-1:0]         mode_now,
  output logic [cstm_pkg::PHASE_W-1:0]        phase_now
);

  logic [cstm_pkg::PHASE_W-1:0] phase_r, phase_nxt;
  logic [cstm_pkg::MODE_W-1:0]  cur_r, cur_nxt;
  logic [cstm_pkg::MODE_W-1:0]  req_r, req_nxt;
  logic [cstm_pkg::CNT_W-1:0]   settle_r, settle_nxt;
  logic                         rem_l_r, rem_l_nxt;
  logic                         rem_r_r, rem_r_nxt;
  logic                         pend_r, pend_nxt;

  logic signed [cstm_pkg::DRIVE_W-1:0] pos_drv, neg_drv;
  logic signed [cstm_pkg::DRIVE_W-1:0] ld, rd, md_l, md_r;
  logic                                fin;

  assign pos_drv = $signed({1'b0, drive_level});
  assign neg_drv = -pos_drv;

  // Sample in every phase except running in stop
  assign smp_ctl.commit = commit;
  assign smp_ctl.sample = !(phase_r == cstm_pkg::PH_RUN && cur_r == cstm_pkg::MODE_STOP);

  // Drives for the current mode
  always_comb begin
    unique case (cur_r)
      cstm_pkg::MODE_FWD:   begin md_l = pos_drv; md_r = pos_drv; end
      cstm_pkg::MODE_BACK:  begin md_l = neg_drv; md_r = neg_drv; end
      cstm_pkg::MODE_LEFT:  begin md_l = neg_drv; md_r = pos_drv; end
      cstm_pkg::MODE_RIGHT: begin md_l = pos_drv; md_r = neg_drv; end
      default:              begin md_l = '0;      md_r = '0;      end
    endcase
  end

  // Step logic for one word
  always_comb begin
    phase_nxt  = phase_r;
    cur_nxt    = cur_r;
    req_nxt    = req_r;
    settle_nxt = settle_r;
    rem_l_nxt  = rem_l_r;
    rem_r_nxt  = rem_r_r;
    pend_nxt   = pend_r;
    ld         = '0;
    rd         = '0;
    fin        = 1'b0;

    unique case (phase_r)
      cstm_pkg::PH_SETTLE: begin
        settle_nxt = settle_r + 1'b1;
        if (settle_nxt >= cstm_pkg::CNT_W'(SETTLE_SAMPLES)) begin
          phase_nxt = cstm_pkg::PH_L_HIGH;
          ld        = neg_drv;
        end
      end
      cstm_pkg::PH_L_HIGH: begin
        ld = neg_drv;
        if (left_level) phase_nxt = cstm_pkg::PH_L_LOW;
      end
      cstm_pkg::PH_L_LOW: begin
        ld = neg_drv;
        if (!left_level) begin
          phase_nxt = cstm_pkg::PH_R_HIGH;
          ld        = '0;
          rd        = neg_drv;
        end
      end
      cstm_pkg::PH_R_HIGH: begin
        rd = neg_drv;
        if (right_level) phase_nxt = cstm_pkg::PH_R_LOW;
      end
      cstm_pkg::PH_R_LOW: begin
        rd = neg_drv;
        if (!right_level) begin
          rd        = '0;
          rem_l_nxt = left_level;
          rem_r_nxt = right_level;
          pend_nxt  = 1'b1;
          cur_nxt   = cstm_pkg::MODE_STOP;
          req_nxt   = cstm_pkg::MODE_STOP;
          phase_nxt = cstm_pkg::PH_RUN;
        end
      end
      cstm_pkg::PH_RUN: begin
        // Take clicks, stop first
        priority if (click_stop)  req_nxt = cstm_pkg::MODE_STOP;
        else if (click_right)     req_nxt = cstm_pkg::MODE_RIGHT;
        else if (click_left)      req_nxt = cstm_pkg::MODE_LEFT;
        else if (click_down)      req_nxt = cstm_pkg::MODE_BACK;
        else if (click_up)        req_nxt = cstm_pkg::MODE_FWD;
        else                      req_nxt = req_r;
        ld  = md_l;
        rd  = md_r;
        fin = 1'b1;
        if (cur_r != cstm_pkg::MODE_STOP) begin
          priority if ((left_level != rem_l_r) && (right_level != rem_r_r)) begin
            pend_nxt = 1'b1;
          end else if (left_level != rem_l_r) begin
            ld        = '0;
            phase_nxt = cstm_pkg::PH_L_HELD;
            fin       = 1'b0;
          end else if (right_level != rem_r_r) begin
            rd        = '0;
            phase_nxt = cstm_pkg::PH_R_HELD;
            fin       = 1'b0;
          end else begin
            pend_nxt = pend_r;
          end
        end
      end
      cstm_pkg::PH_L_HELD: begin
        ld = md_l;
        rd = md_r;
        if (right_level != rem_r_r) begin
          pend_nxt  = 1'b1;
          phase_nxt = cstm_pkg::PH_RUN;
          fin       = 1'b1;
        end else begin
          ld = '0;
        end
      end
      default: begin
        ld = md_l;
        rd = md_r;
        if (left_level != rem_l_r) begin
          pend_nxt  = 1'b1;
          phase_nxt = cstm_pkg::PH_RUN;
          fin       = 1'b1;
        end else begin
          rd = '0;
        end
      end
    endcase

    // Finish a running or releasing word
    if (fin) begin
      if (cur_nxt == cstm_pkg::MODE_STOP) cur_nxt = req_nxt;
      if (pend_nxt) begin
        rem_l_nxt = !rem_l_nxt;
        rem_r_nxt = !rem_r_nxt;
        pend_nxt  = 1'b0;
        cur_nxt   = req_nxt;
        if (cur_nxt == cstm_pkg::MODE_STOP) begin
          ld = '0;
          rd = '0;
        end
      end
    end
  end

  // Commit the state of a processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= cstm_pkg::PH_SETTLE;
      cur_r    <= cstm_pkg::MODE_STOP;
      req_r    <= cstm_pkg::MODE_STOP;
      settle_r <= '0;
      rem_l_r  <= 1'b0;
      rem_r_r  <= 1'b0;
      pend_r   <= 1'b0;
    end else if (commit) begin
      phase_r  <= phase_nxt;
      cur_r    <= cur_nxt;
      req_r    <= req_nxt;
      settle_r <= settle_nxt;
      rem_l_r  <= rem_l_nxt;
      rem_r_r  <= rem_r_nxt;
      pend_r   <= pend_nxt;
    end
  end

  assign left_drive  = ld;
  assign right_drive = rd;
  assign mode_now    = cur_nxt;
  assign phase_now   = phase_nxt;

endmodule

>>> rtl/core/cam_synced_two_motor_drive_unit.sv
// ----------------------------------------------------------------------------
// cam_synced_two_motor_drive_unit
// Debounces two cam switches, homes both cams and drives two motors in step.
// ----------------------------------------------------------------------------
// Takes one input word per clock while in_stall is low and returns one result
// word per input word. A word passes an input register and a result register.
// The result register loads a word's result once the word sits in the input
// register and the result register is free or being taken; it holds its word
// while out_stall is high. The step logic between those registers is
// combinational, so a new word can enter as the last one moves on.
// The user must write configuration over the APB port only while no words are
// in flight; the block itself does not enforce it.
module cam_synced_two_motor_drive_unit #(
  parameter int HISTORY_BITS   = cstm_pkg::HISTORY_BITS_DEF,
  parameter int SETTLE_SAMPLES = cstm_pkg::SETTLE_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_left_switch,
  input  logic                                in_right_switch,
  input  logic                                in_click_up,
  input  logic                                in_click_down,
  input  logic                                in_click_left,
  input  logic                                in_click_right,
  input  logic                                in_click_stop,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [cstm_pkg::DRIVE_W-1:0] out_left_drive,
  output logic signed [cstm_pkg::DRIVE_W-1:0] out_right_drive,
  output logic [cstm_pkg::MODE_W-1:0]         out_mode_now,
  output logic [cstm_pkg::PHASE_W-1:0]        out_phase_now,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cstm_pkg::PADDR_W-1:0]        paddr,
  input  logic [cstm_pkg::PDATA_W-1:0]        pwdata,
  output logic [cstm_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  // Input register
  logic in_v_r;
  logic lsw_r, rsw_r, up_r, down_r, left_r, right_r, stop_r;
  // Result register
  logic                                out_v_r;
  logic signed [cstm_pkg::DRIVE_W-1:0] ld_r, rd_r;
  logic [cstm_pkg::MODE_W-1:0]         mode_r;
  logic [cstm_pkg::PHASE_W-1:0]        phase_r;

  logic                                advance;
  logic                                in_take;
  cstm_pkg::smp_ctl_t                  smp_ctl;
  logic [cstm_pkg::MASK_W-1:0]         debounce_mask;
  logic [cstm_pkg::LEVEL_W-1:0]        drive_level;
  logic                                lvl_l, lvl_r;
  logic signed [cstm_pkg::DRIVE_W-1:0] ld_nxt, rd_nxt;
  logic [cstm_pkg::MODE_W-1:0]         mode_nxt;
  logic [cstm_pkg::PHASE_W-1:0]        phase_nxt;

  // Move a word into the result register when that register is free
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      lsw_r   <= in_left_switch;
      rsw_r   <= in_right_switch;
      up_r    <= in_click_up;
      down_r  <= in_click_down;
      left_r  <= in_click_left;
      right_r <= in_click_right;
      stop_r  <= in_click_stop;
    end
  end

  cstm_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .debounce_mask (debounce_mask),
    .drive_level   (drive_level)
  );

  cstm_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_deb_l (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (smp_ctl),
    .raw           (lsw_r),
    .debounce_mask (debounce_mask),
    .level_post    (lvl_l)
  );

  cstm_debounce #(.HISTORY_BITS(HISTORY_BITS)) u_deb_r (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (smp_ctl),
    .raw           (rsw_r),
    .debounce_mask (debounce_mask),
    .level_post    (lvl_r)
  );

  cstm_ctrl #(.SETTLE_SAMPLES(SETTLE_SAMPLES)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .commit      (advance),
    .click_up    (up_r),
    .click_down  (down_r),
    .click_left  (left_r),
    .click_right (right_r),
    .click_stop  (stop_r),
    .left_level  (lvl_l),
    .right_level (lvl_r),
    .drive_level (drive_level),
    .smp_ctl     (smp_ctl),
    .left_drive  (ld_nxt),
    .right_drive (rd_nxt),
    .mode_now    (mode_nxt),
    .phase_now   (phase_nxt)
  );

  // Result register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ld_r    <= ld_nxt;
      rd_r    <= rd_nxt;
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_left_drive  = ld_r;
  assign out_right_drive = rd_r;
  assign out_mode_now    = mode_r;
  assign out_phase_now   = phase_r;

endmodule

>>> bench/cam_synced_two_motor_drive_unit_tb.sv
// ----------------------------------------------------------------------------
// cam_synced_two_motor_drive_unit_tb
// Checks the two-motor cam drive against a cycle-free predictor of its ticks.
// A directed opening homes both cams and walks every mode, click priority and
// cam hold. Random phases follow, each under its own debounce mask and drive
// level, with slow switch waves, glitches and clicks. Sender bursts and
// receiver stalls vary throughout the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cam_synced_two_motor_drive_unit_tb;

  localparam int HIST_W     = cstm_pkg::HISTORY_BITS_DEF;
  localparam int LATENCY    = 2;
  localparam int IDLE_LIMIT = 600;

  localparam logic [cstm_pkg::PADDR_W-1:0] ADDR_MASK  = {cstm_pkg::REG_SEL_MASK, 2'b00};
  localparam logic [cstm_pkg::PADDR_W-1:0] ADDR_LEVEL = {cstm_pkg::REG_SEL_LEVEL, 2'b00};

  // Click sets, ordered {up, down, left, right, stop}
  localparam logic [4:0] CLK_NONE  = 5'b00000;
  localparam logic [4:0] CLK_UP    = 5'b10000;
  localparam logic [4:0] CLK_DOWN  = 5'b01000;
  localparam logic [4:0] CLK_LEFT  = 5'b00100;
  localparam logic [4:0] CLK_RIGHT = 5'b00010;
  localparam logic [4:0] CLK_STOP  = 5'b00001;
  localparam logic [4:0] CLK_ALL   = 5'b11111;

  typedef struct packed {
    logic left_switch;
    logic right_switch;
    logic click_up;
    logic click_down;
    logic click_left;
    logic click_right;
    logic click_stop;
  } tick_t;

  typedef struct packed {
    logic signed [cstm_pkg::DRIVE_W-1:0] left_drive;
    logic signed [cstm_pkg::DRIVE_W-1:0] right_drive;
    logic [cstm_pkg::MODE_W-1:0]         mode_now;
    logic [cstm_pkg::PHASE_W-1:0]        phase_now;
  } drive_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_TOGGLE, STALL_LONG} stall_style_t;

  // Tracks the drive unit tick by tick and holds the results still owed
  class drive_predictor_t;
    logic [cstm_pkg::MASK_W-1:0]  debounce_mask;
    logic [cstm_pkg::LEVEL_W-1:0] drive_level;
    logic [HIST_W-1:0]            l_hist, r_hist;
    logic                         l_lvl, r_lvl, l_mem, r_mem, pend;
    logic [cstm_pkg::MODE_W-1:0]  mode, req;
    logic [cstm_pkg::PHASE_W-1:0] phase;
    logic [cstm_pkg::CNT_W-1:0]   settle_cnt;
    drive_t                       pending_drives[$];
    int                           mismatches, checked, ticks, holds;
    logic [7:0]                   phases_seen;
    logic [4:0]                   modes_seen;

    function new();
      debounce_mask = cstm_pkg::MASK_RST;
      drive_level   = cstm_pkg::LEVEL_RST;
      l_hist = '0;
      r_hist = '0;
      l_lvl = 1'b0;
      r_lvl = 1'b0;
      l_mem = 1'b0;
      r_mem = 1'b0;
      pend  = 1'b0;
      mode  = cstm_pkg::MODE_STOP;
      req   = cstm_pkg::MODE_STOP;
      phase = cstm_pkg::PH_SETTLE;
      settle_cnt  = '0;
      mismatches  = 0;
      checked     = 0;
      ticks       = 0;
      holds       = 0;
      phases_seen = '0;
      modes_seen  = '0;
    endfunction

    function void write_reg(logic [cstm_pkg::PADDR_W-1:0] addr,
                            logic [cstm_pkg::PDATA_W-1:0] data);
      if (addr[2] == cstm_pkg::REG_SEL_MASK) begin
        debounce_mask = data[cstm_pkg::MASK_W-1:0];
      end else begin
        drive_level = data[cstm_pkg::LEVEL_W-1:0];
      end
    endfunction

    // Shift one sample pair into the histories and settle the levels
    function void shift_in(logic l, logic r);
      logic [HIST_W-1:0] m;
      m = HIST_W'(debounce_mask);
      l_hist = {l_hist[HIST_W-2:0], l};
      r_hist = {r_hist[HIST_W-2:0], r};
      if ((l_hist & m) == m) l_lvl = 1'b1;
      else if ((l_hist & m) == '0) l_lvl = 1'b0;
      if ((r_hist & m) == m) r_lvl = 1'b1;
      else if ((r_hist & m) == '0) r_lvl = 1'b0;
    endfunction

    function void mode_drives(logic [cstm_pkg::MODE_W-1:0] m, output int ld, output int rd);
      int p;
      p = int'(drive_level);
      case (m)
        cstm_pkg::MODE_FWD:   begin ld = p;  rd = p;  end
        cstm_pkg::MODE_BACK:  begin ld = -p; rd = -p; end
        cstm_pkg::MODE_LEFT:  begin ld = -p; rd = p;  end
        cstm_pkg::MODE_RIGHT: begin ld = p;  rd = -p; end
        default:              begin ld = 0;  rd = 0;  end
      endcase
    endfunction

    // End of a running or releasing tick: take requests, apply a pending change
    function void finish_tick(inout int ld, inout int rd);
      if (mode == cstm_pkg::MODE_STOP && req != cstm_pkg::MODE_STOP) mode = req;
      if (pend) begin
        l_mem = ~l_mem;
        r_mem = ~r_mem;
        pend  = 1'b0;
        mode  = req;
        if (mode == cstm_pkg::MODE_STOP) begin
          ld = 0;
          rd = 0;
        end
      end
    endfunction

    function void take_tick(tick_t w);
      int     ld, rd, neg;
      logic   held, lch, rch;
      drive_t d;
      ld = 0;
      rd = 0;
      neg = -int'(drive_level);
      held = 1'b0;
      ticks++;
      case (phase)
        cstm_pkg::PH_SETTLE: begin
          shift_in(w.left_switch, w.right_switch);
          settle_cnt = settle_cnt + 1'b1;
          if (settle_cnt >= cstm_pkg::SETTLE_SAMPLES_DEF) begin
            phase = cstm_pkg::PH_L_HIGH;
            ld = neg;
          end
        end
        cstm_pkg::PH_L_HIGH: begin
          shift_in(w.left_switch, w.right_switch);
          ld = neg;
          if (l_lvl) phase = cstm_pkg::PH_L_LOW;
        end
        cstm_pkg::PH_L_LOW: begin
          shift_in(w.left_switch, w.right_switch);
          ld = neg;
          if (!l_lvl) begin
            phase = cstm_pkg::PH_R_HIGH;
            ld = 0;
            rd = neg;
          end
        end
        cstm_pkg::PH_R_HIGH: begin
          shift_in(w.left_switch, w.right_switch);
          rd = neg;
          if (r_lvl) phase = cstm_pkg::PH_R_LOW;
        end
        cstm_pkg::PH_R_LOW: begin
          shift_in(w.left_switch, w.right_switch);
          rd = neg;
          if (!r_lvl) begin
            rd = 0;
            l_mem = l_lvl;
            r_mem = r_lvl;
            pend  = 1'b1;
            mode  = cstm_pkg::MODE_STOP;
            req   = cstm_pkg::MODE_STOP;
            phase = cstm_pkg::PH_RUN;
          end
        end
        cstm_pkg::PH_RUN: begin
          // Later clicks win: stop beats right beats left beats down beats up
          if (w.click_up)    req = cstm_pkg::MODE_FWD;
          if (w.click_down)  req = cstm_pkg::MODE_BACK;
          if (w.click_left)  req = cstm_pkg::MODE_LEFT;
          if (w.click_right) req = cstm_pkg::MODE_RIGHT;
          if (w.click_stop)  req = cstm_pkg::MODE_STOP;
          mode_drives(mode, ld, rd);
          if (mode != cstm_pkg::MODE_STOP) begin
            shift_in(w.left_switch, w.right_switch);
            lch = l_lvl != l_mem;
            rch = r_lvl != r_mem;
            if (lch && rch) begin
              pend = 1'b1;
            end else if (lch) begin
              ld = 0;
              phase = cstm_pkg::PH_L_HELD;
              held = 1'b1;
            end else if (rch) begin
              rd = 0;
              phase = cstm_pkg::PH_R_HELD;
              held = 1'b1;
            end
          end
          if (held) holds++;
          else finish_tick(ld, rd);
        end
        cstm_pkg::PH_L_HELD: begin
          shift_in(w.left_switch, w.right_switch);
          mode_drives(mode, ld, rd);
          if (r_lvl != r_mem) begin
            pend = 1'b1;
            phase = cstm_pkg::PH_RUN;
            finish_tick(ld, rd);
          end else begin
            ld = 0;
          end
        end
        default: begin
          shift_in(w.left_switch, w.right_switch);
          mode_drives(mode, ld, rd);
          if (l_lvl != l_mem) begin
            pend = 1'b1;
            phase = cstm_pkg::PH_RUN;
            finish_tick(ld, rd);
          end else begin
            rd = 0;
          end
        end
      endcase
      d.left_drive  = ld[cstm_pkg::DRIVE_W-1:0];
      d.right_drive = rd[cstm_pkg::DRIVE_W-1:0];
      d.mode_now    = mode;
      d.phase_now   = phase;
      pending_drives.push_back(d);
      phases_seen[phase] = 1'b1;
      modes_seen[mode]   = 1'b1;
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (pending_drives.size() == 0) begin
        $error("result word with no input word pending");
        mismatches++;
        return;
      end
      want = pending_drives.pop_front();
      checked++;
      if (got.left_drive !== want.left_drive) begin
        $error("left_drive: expected %0d, got %0d", want.left_drive, got.left_drive);
        mismatches++;
      end
      if (got.right_drive !== want.right_drive) begin
        $error("right_drive: expected %0d, got %0d", want.right_drive, got.right_drive);
        mismatches++;
      end
      if (got.mode_now !== want.mode_now) begin
        $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
        mismatches++;
      end
      if (got.phase_now !== want.phase_now) begin
        $error("phase_now: expected %0d, got %0d", want.phase_now, got.phase_now);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  tick_t cur_tick;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cstm_pkg::DRIVE_W-1:0] out_left_drive, out_right_drive;
  logic [cstm_pkg::MODE_W-1:0]  out_mode_now;
  logic [cstm_pkg::PHASE_W-1:0] out_phase_now;
  logic psel, penable, pwrite, pready;
  logic [cstm_pkg::PADDR_W-1:0] paddr;
  logic [cstm_pkg::PDATA_W-1:0] pwdata, prdata;
  drive_t out_word;

  drive_predictor_t pred = new();

  int burst_left = 0;
  int idle_cycles = 0;
  int settings = 0;
  logic l_wave = 1'b0;
  logic r_wave = 1'b0;
  int l_run = 0;
  int r_run = 0;
  stall_style_t stall_style = STALL_NONE;
  int stall_left_cyc = 0;
  int stall_run = 0;

  assign out_word = {out_left_drive, out_right_drive, out_mode_now, out_phase_now};

  cam_synced_two_motor_drive_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_left_switch  (cur_tick.left_switch),
    .in_right_switch (cur_tick.right_switch),
    .in_click_up     (cur_tick.click_up),
    .in_click_down   (cur_tick.click_down),
    .in_click_left   (cur_tick.click_left),
    .in_click_right  (cur_tick.click_right),
    .in_click_stop   (cur_tick.click_stop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_left_drive  (out_left_drive),
    .out_right_drive (out_right_drive),
    .out_mode_now    (out_mode_now),
    .out_phase_now   (out_phase_now),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stall pattern: pick a random style, and a new one when its span runs out
  always @(negedge clk) begin
    if (stall_left_cyc == 0) begin
      stall_style = stall_style_t'($urandom_range(0, 3));
      stall_left_cyc = $urandom_range(20, 120);
    end
    stall_left_cyc--;
    case (stall_style)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_TOGGLE: out_stall <= ~out_stall;
      default: begin
        if (stall_run > 0) begin
          out_stall <= 1'b1;
          stall_run--;
        end else begin
          out_stall <= 1'b0;
          if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // Note accepted words, check results, and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) pred.take_tick(cur_tick);
      if (out_valid && !out_stall) pred.check_drive(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Send one word, opening a new burst after a random gap when one runs out
  task automatic send_word(tick_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    cur_tick <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every owed result is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pred.pending_drives.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic reg_write(logic [cstm_pkg::PADDR_W-1:0] addr,
                           logic [cstm_pkg::PDATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pred.write_reg(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read(logic [cstm_pkg::PADDR_W-1:0] addr,
                          logic [cstm_pkg::PDATA_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata at %0d: expected %0d, got %0d", addr, want, prdata);
      pred.mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Slow switch waves with the odd glitch; the right cam often flips with the left
  function automatic tick_t random_tick(int max_run, int click_odds);
    tick_t w;
    if (l_run == 0) begin
      l_wave = ~l_wave;
      l_run = $urandom_range(1, max_run);
      if ($urandom_range(0, 2) == 0) begin
        r_wave = ~r_wave;
        r_run = $urandom_range(1, max_run);
      end
    end else begin
      l_run--;
    end
    if (r_run == 0) begin
      r_wave = ~r_wave;
      r_run = $urandom_range(1, max_run);
    end else begin
      r_run--;
    end
    w.left_switch  = l_wave ^ ($urandom_range(0, 24) == 0);
    w.right_switch = r_wave ^ ($urandom_range(0, 24) == 0);
    w.click_up     = ($urandom_range(1, click_odds) == 1);
    w.click_down   = ($urandom_range(1, click_odds) == 1);
    w.click_left   = ($urandom_range(1, click_odds) == 1);
    w.click_right  = ($urandom_range(1, click_odds) == 1);
    w.click_stop   = ($urandom_range(1, 2 * click_odds) == 1);
    return w;
  endfunction

  task automatic run_phase(logic [cstm_pkg::MASK_W-1:0] mask,
                           logic [cstm_pkg::LEVEL_W-1:0] level,
                           int max_run, int count);
    drain();
    reg_write(ADDR_MASK, cstm_pkg::PDATA_W'(mask));
    reg_write(ADDR_LEVEL, cstm_pkg::PDATA_W'(level));
    settings++;
    repeat (count) send_word(random_tick(max_run, 10));
  endtask

  initial begin
    cur_tick = '0;
    in_valid = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    reg_read(ADDR_MASK, cstm_pkg::PDATA_W'(cstm_pkg::MASK_RST));
    reg_read(ADDR_LEVEL, cstm_pkg::PDATA_W'(cstm_pkg::LEVEL_RST));

    // Single-sample debounce and full drive keep homing short
    reg_write(ADDR_MASK, 32'd1);
    reg_write(ADDR_LEVEL, 32'd1023);
    settings++;

    // Settle, then home left and right; clicks here are ignored
    send_word({1'b0, 1'b0, CLK_ALL});
    repeat (14) send_word({1'b0, 1'b0, CLK_NONE});
    send_word({1'b1, 1'b0, CLK_NONE});
    send_word({1'b0, 1'b0, CLK_NONE});
    send_word({1'b0, 1'b1, CLK_NONE});
    send_word({1'b0, 1'b0, CLK_NONE});

    // Run forward, hold the left cam, release, then stop by priority
    send_word({1'b0, 1'b0, CLK_UP});
    send_word({1'b0, 1'b0, CLK_NONE});
    send_word({1'b1, 1'b0, CLK_NONE});
    send_word({1'b1, 1'b0, CLK_NONE});
    send_word({1'b1, 1'b1, CLK_ALL});
    send_word({1'b1, 1'b1, CLK_ALL});
    send_word({1'b0, 1'b0, CLK_NONE});

    // Right turn wins over the rest, hold the right cam, then left, back, stop
    send_word({1'b0, 1'b0, CLK_UP | CLK_DOWN | CLK_LEFT | CLK_RIGHT});
    send_word({1'b0, 1'b0, CLK_UP | CLK_DOWN | CLK_LEFT});
    send_word({1'b0, 1'b1, CLK_NONE});
    send_word({1'b1, 1'b1, CLK_NONE});
    send_word({1'b1, 1'b1, CLK_UP | CLK_DOWN});
    send_word({1'b0, 1'b0, CLK_NONE});
    send_word({1'b0, 1'b0, CLK_UP});
    send_word({1'b1, 1'b1, CLK_STOP});

    // Random phases across the register extremes; zero mask pins both levels high
    run_phase(16'h00FF, 10'd512, 30, 260);
    run_phase(16'hFFFF, 10'd0, 60, 200);
    run_phase(16'h0001, 10'd1023, 6, 260);
    run_phase(16'h0000, 10'd1, 20, 120);
    run_phase(cstm_pkg::MASK_W'($urandom_range(1, 16'hFFFF)),
              cstm_pkg::LEVEL_W'($urandom_range(0, 1023)), 40, 280);

    drain();
    repeat (LATENCY + 4) @(posedge clk);

    $display("Sent %0d words under %0d register settings, checked %0d results, %0d cam holds",
             pred.ticks, settings, pred.checked, pred.holds);
    $display("Phases reached %b, modes reached %b", pred.phases_seen, pred.modes_seen);
    if (pred.mismatches == 0 && pred.pending_drives.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/cstm_pkg.sv
rtl/core/cstm_cfg.sv
rtl/core/cstm_debounce.sv
rtl/core/cstm_ctrl.sv
rtl/core/cam_synced_two_motor_drive_unit.sv
bench/cam_synced_two_motor_drive_unit_tb.sv
